@@ design/sfs_pkg.sv @@
package sfs_pkg;

  localparam int INDEX_BITS_DEF = 8;
  localparam int TIME_BITS_DEF  = 32;

  localparam int KIND_W   = 3;
  localparam int TIME_W   = 32;
  localparam int POS_W    = 8;
  localparam int PERIOD_W = 32;
  localparam int UV_W     = 17;
  localparam int OFF_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // one in Q1.16
  localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_PLAY    = 3'd1,
    KIND_RESUME  = 3'd2,
    KIND_PAUSE   = 3'd3,
    KIND_STOP    = 3'd4,
    KIND_RESTART = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_COL      = 3'd0,
    CFG_MAX_ROW      = 3'd1,
    CFG_END_COL      = 3'd2,
    CFG_FRAME_PERIOD = 3'd3,
    CFG_LOOP_ENABLE  = 3'd4,
    CFG_UV_STEP_X    = 3'd5,
    CFG_UV_STEP_Y    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]    max_col;
    logic [POS_W-1:0]    max_row;
    logic [POS_W-1:0]    end_col;
    logic [PERIOD_W-1:0] frame_period;
    logic                loop_enable;
    logic [UV_W-1:0]     uv_step_x;
    logic [UV_W-1:0]     uv_step_y;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic run;
    logic ended;
  } stat_t;

endpackage

@@ design/sfs_in_if.sv @@
interface sfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [sfs_pkg::KIND_W-1:0]  kind;
  logic [sfs_pkg::TIME_W-1:0]  delta_time;

  modport source (output valid, kind, delta_time, input ready);
  modport sink   (input valid, kind, delta_time, output ready);
endinterface

@@ design/sfs_out_if.sv @@
interface sfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfs_pkg::POS_W-1:0]  frame_col;
  logic [sfs_pkg::POS_W-1:0]  frame_row;
  logic                       playing;
  logic                       ended;
  logic [sfs_pkg::UV_W-1:0]   uv_scale_x;
  logic [sfs_pkg::UV_W-1:0]   uv_scale_y;
  logic [sfs_pkg::OFF_W-1:0]  uv_offset_x;
  logic [sfs_pkg::OFF_W-1:0]  uv_offset_y;

  modport source (output valid, frame_col, frame_row, playing, ended, uv_scale_x,
                  uv_scale_y, uv_offset_x, uv_offset_y, input ready);
  modport sink   (input valid, frame_col, frame_row, playing, ended, uv_scale_x,
                  uv_scale_y, uv_offset_x, uv_offset_y, output ready);
endinterface

@@ design/sfs_cfg_regs.sv @@
module sfs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output sfs_pkg::cfg_t                       cfg_o
);

  sfs_pkg::cfg_t cfg_q;
  sfs_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sfs_pkg::cfg_idx_e'(cfg_idx_i))
        sfs_pkg::CFG_MAX_COL:      cfg_d.max_col      = cfg_data_i[sfs_pkg::POS_W-1:0];
        sfs_pkg::CFG_MAX_ROW:      cfg_d.max_row      = cfg_data_i[sfs_pkg::POS_W-1:0];
        sfs_pkg::CFG_END_COL:      cfg_d.end_col      = cfg_data_i[sfs_pkg::POS_W-1:0];
        sfs_pkg::CFG_FRAME_PERIOD: cfg_d.frame_period = cfg_data_i[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::CFG_LOOP_ENABLE:  cfg_d.loop_enable  = cfg_data_i[0];
        sfs_pkg::CFG_UV_STEP_X:    cfg_d.uv_step_x    = cfg_data_i[sfs_pkg::UV_W-1:0];
        sfs_pkg::CFG_UV_STEP_Y:    cfg_d.uv_step_y    = cfg_data_i[sfs_pkg::UV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_col      <= '0;
      cfg_q.max_row      <= '0;
      cfg_q.end_col      <= '0;
      cfg_q.frame_period <= '0;
      cfg_q.loop_enable  <= 1'b0;
      cfg_q.uv_step_x    <= sfs_pkg::UV_ONE;
      cfg_q.uv_step_y    <= sfs_pkg::UV_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/sfs_seq_core.sv @@
module sfs_seq_core #(
  parameter int INDEX_BITS = sfs_pkg::INDEX_BITS_DEF,
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sfs_in_if.sink                 in_i,
  input  sfs_pkg::cfg_t          cfg_i,
  input  logic                   take_i,
  output sfs_pkg::stat_t         stat_o,
  output logic [INDEX_BITS-1:0]  col_o,
  output logic [INDEX_BITS-1:0]  row_o
);

  localparam int IW = (INDEX_BITS > sfs_pkg::POS_W) ? INDEX_BITS : sfs_pkg::POS_W;
  localparam int CW = (TIME_BITS > sfs_pkg::PERIOD_W) ? TIME_BITS : sfs_pkg::PERIOD_W;

  // input stage
  logic                         a_valid_q;
  sfs_pkg::kind_e               a_kind_q;
  logic [sfs_pkg::TIME_W-1:0]   a_dt_q;

  // animation state, also the payload of the result stage
  logic                         b_valid_q;
  logic [TIME_BITS-1:0]         elapsed_q, elapsed_d;
  logic [INDEX_BITS-1:0]        col_q, col_d;
  logic [INDEX_BITS-1:0]        row_q, row_d;
  logic                         run_q, run_d;
  logic                         end_q, end_d;

  logic                         en_b;
  logic                         en_a;
  logic                         in_fire;
  logic                         a_fire;
  logic                         single;
  logic [TIME_BITS:0]           sum;
  logic [TIME_BITS-1:0]         sat;
  logic                         reach;
  logic                         at_end;
  logic [INDEX_BITS:0]          col_inc;
  logic                         col_wrap;

  assign en_b    = !b_valid_q || take_i;
  assign en_a    = !a_valid_q || en_b;
  assign in_fire = in_i.valid && en_a;
  assign a_fire  = a_valid_q && en_b;
  assign in_i.ready = en_a;

  assign single  = (cfg_i.max_col == '0) && (cfg_i.max_row == '0);
  assign sum     = {1'b0, elapsed_q} + (TIME_BITS+1)'(TIME_BITS'(a_dt_q));
  assign sat     = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign reach   = CW'(sat) >= CW'(cfg_i.frame_period);
  assign at_end  = (IW'(col_q) == IW'(cfg_i.end_col)) && (IW'(row_q) == IW'(cfg_i.max_row));
  assign col_inc = {1'b0, col_q} + (INDEX_BITS+1)'(1);
  assign col_wrap = (IW+1)'(col_inc) > (IW+1)'(cfg_i.max_col);

  always_comb begin
    elapsed_d = elapsed_q;
    col_d     = col_q;
    row_d     = row_q;
    run_d     = run_q;
    end_d     = end_q;
    case (a_kind_q)
      sfs_pkg::KIND_TICK: begin
        if (!single && run_q) begin
          elapsed_d = sat;
          if (reach) begin
            elapsed_d = '0;
            if (at_end) begin
              col_d = '0;
              row_d = '0;
              if (!cfg_i.loop_enable) begin
                end_d = 1'b1;
                run_d = 1'b0;
              end
            end else if (col_wrap) begin
              col_d = '0;
              row_d = row_q + INDEX_BITS'(1);
            end else begin
              col_d = col_inc[INDEX_BITS-1:0];
            end
          end
        end
      end
      sfs_pkg::KIND_PLAY: begin
        col_d     = '0;
        row_d     = '0;
        run_d     = 1'b1;
        end_d     = 1'b0;
        elapsed_d = '0;
      end
      sfs_pkg::KIND_RESUME: begin
        run_d     = 1'b1;
        end_d     = 1'b0;
        elapsed_d = '0;
      end
      sfs_pkg::KIND_PAUSE: begin
        run_d = 1'b0;
      end
      sfs_pkg::KIND_STOP: begin
        run_d = 1'b0;
        col_d = '0;
        row_d = '0;
      end
      sfs_pkg::KIND_RESTART: begin
        col_d     = '0;
        row_d     = '0;
        elapsed_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
      end else if (take_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_kind_q <= sfs_pkg::kind_e'(in_i.kind);
      a_dt_q   <= in_i.delta_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      run_q     <= 1'b0;
      end_q     <= 1'b0;
    end else if (a_fire) begin
      elapsed_q <= elapsed_d;
      col_q     <= col_d;
      row_q     <= row_d;
      run_q     <= run_d;
      end_q     <= end_d;
    end
  end

  assign stat_o.valid = b_valid_q;
  assign stat_o.run   = run_q;
  assign stat_o.ended = end_q;
  assign col_o        = col_q;
  assign row_o        = row_q;

`ifndef SYNTHESIS
  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_fire |=> ($stable(col_q) && $stable(row_q) && $stable(elapsed_q)))
    else $error("animation state changed without an item");

  a_single_frame_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && a_kind_q == sfs_pkg::KIND_TICK && single)
      |=> ($stable(col_q) && $stable(row_q) && $stable(elapsed_q)))
    else $error("single frame sheet advanced on a tick");

  a_end_stops_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(end_q) |-> (!run_q && col_q == '0 && row_q == '0))
    else $error("end flag set while still playing or off frame zero");
`endif

endmodule

@@ design/sfs_uv_stage.sv @@
module sfs_uv_stage #(
  parameter int INDEX_BITS = sfs_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfs_pkg::stat_t         stat_i,
  input  logic [INDEX_BITS-1:0]  col_i,
  input  logic [INDEX_BITS-1:0]  row_i,
  input  sfs_pkg::cfg_t          cfg_i,
  output logic                   take_o,
  sfs_out_if.source              out_o
);

  logic                          c_valid_q;
  logic [sfs_pkg::POS_W-1:0]     col_q;
  logic [sfs_pkg::POS_W-1:0]     row_q;
  logic                          run_q;
  logic                          end_q;
  logic [sfs_pkg::UV_W-1:0]      scale_x_q;
  logic [sfs_pkg::UV_W-1:0]      scale_y_q;
  logic [sfs_pkg::OFF_W-1:0]     off_x_q, off_x_d;
  logic [sfs_pkg::OFF_W-1:0]     off_y_q, off_y_d;
  logic                          load;

  assign take_o = stat_i.valid && (!c_valid_q || out_o.ready);
  assign load   = take_o;

  // products kept to the low 24 bits
  assign off_x_d = sfs_pkg::OFF_W'(col_i) * sfs_pkg::OFF_W'(cfg_i.uv_step_x);
  assign off_y_d = sfs_pkg::OFF_W'(row_i) * sfs_pkg::OFF_W'(cfg_i.uv_step_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (load) begin
      c_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      c_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q     <= sfs_pkg::POS_W'(col_i);
      row_q     <= sfs_pkg::POS_W'(row_i);
      run_q     <= stat_i.run;
      end_q     <= stat_i.ended;
      scale_x_q <= cfg_i.uv_step_x;
      scale_y_q <= cfg_i.uv_step_y;
      off_x_q   <= off_x_d;
      off_y_q   <= off_y_d;
    end
  end

  assign out_o.valid       = c_valid_q;
  assign out_o.frame_col   = col_q;
  assign out_o.frame_row   = row_q;
  assign out_o.playing     = run_q;
  assign out_o.ended       = end_q;
  assign out_o.uv_scale_x  = scale_x_q;
  assign out_o.uv_scale_y  = scale_y_q;
  assign out_o.uv_offset_x = off_x_q;
  assign out_o.uv_offset_y = off_y_q;

endmodule

@@ design/sprite_frame_sequencer_top.sv @@
// stages in order: input register, state update, uv multiply register
// throughput: one word per cycle while the output is not stalled
// the ready path runs combinationally from the output back through each stage
// reset: asynchronous active low; frame 0, stopped, accumulator clear, uv steps at 1.0
module sprite_frame_sequencer_top #(
  parameter int INDEX_BITS = sfs_pkg::INDEX_BITS_DEF,
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfs_in_if.sink                          in_i,
  sfs_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sfs_pkg::cfg_t          cfg;
  sfs_pkg::stat_t         stat;
  logic [INDEX_BITS-1:0]  col;
  logic [INDEX_BITS-1:0]  row;
  logic                   take;

  sfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfs_seq_core #(
    .INDEX_BITS (INDEX_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .take_i (take),
    .stat_o (stat),
    .col_o  (col),
    .row_o  (row)
  );

  sfs_uv_stage #(
    .INDEX_BITS (INDEX_BITS)
  ) u_uv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .col_i  (col),
    .row_i  (row),
    .cfg_i  (cfg),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule
